// ----- rtl/core/bcte_pkg.sv -----
// shared types, constants and helper function of the button colour table engine
`default_nettype none

package bcte_pkg;

	localparam logic       OP_BYTE    = 1'b0;
	localparam logic       OP_REFRESH = 1'b1;
	localparam logic [7:0] CLEAR_CODE = 8'hFF;

	localparam logic [4:0] LED_MAP [32] = '{
		5'd4,  5'd0,  5'd20, 5'd18,
		5'd7,  5'd1,  5'd21, 5'd16,
		5'd6,  5'd3,  5'd23, 5'd19,
		5'd9,  5'd11, 5'd15, 5'd13,
		5'd8,  5'd10, 5'd14, 5'd12,
		5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27,
		5'd28, 5'd29, 5'd30, 5'd31
	};

	typedef enum logic [1:0] {
		PH_BUTTON,
		PH_RED,
		PH_GREEN,
		PH_BLUE
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic scan_start;
		logic issue;
	} cmd_t;

	typedef struct packed {
		logic at_last;
		logic pipe_busy;
	} status_t;

	// exact floor(p / 255) for a product of two bytes
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [7:0] q0;
		logic [8:0] r;
		begin
			q0 = p[15:8];
			r  = {1'b0, p[7:0]} + {1'b0, q0};
			div255 = (r >= 9'd255) ? q0 + 8'd1 : q0;
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/button_colour_table_engine_core.sv -----
// top level of the button colour table engine
// A report byte (operation 0) is taken while idle and busy stays low, so bytes may be
// issued on every cycle. A refresh with layer_active high holds busy while the table is
// scanned and the pipeline drains: the colour table is read one button per cycle and each
// colour passes a two-stage multiply and divide-by-255 pipeline, so one result per button
// appears on consecutive cycles, the last one flagged by last_of_scan.
// A refresh with layer_active low produces no results and leaves busy low. Each result is
// shown for exactly one cycle with result_strobe high; the receiver cannot stall it.
`default_nettype none

module button_colour_table_engine_core #(
	parameter int NUM_BUTTONS = 20
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       operation,
	input  wire logic [7:0] report_byte,
	input  wire logic       last_in_report,
	input  wire logic [7:0] brightness,
	input  wire logic       layer_active,
	output logic            result_strobe,
	output logic [4:0]      led_index,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out,
	output logic            last_of_scan
);
	import bcte_pkg::*;

	cmd_t    cmd;
	status_t status;

	bcte_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.layer_active (layer_active),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy)
	);

	bcte_dp #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.report_byte    (report_byte),
		.last_in_report (last_in_report),
		.brightness     (brightness),
		.status         (status),
		.result_strobe  (result_strobe),
		.led_index      (led_index),
		.red_out        (red_out),
		.green_out      (green_out),
		.blue_out       (blue_out),
		.last_of_scan   (last_of_scan)
	);

endmodule

`default_nettype wire

// ----- rtl/core/bcte_ctrl.sv -----
// controller state machine: report byte dispatch and refresh scan sequencing
`default_nettype none

module bcte_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            operation,
	input  wire logic            layer_active,
	input  wire bcte_pkg::status_t status,
	output bcte_pkg::cmd_t       cmd,
	output logic                 busy
);
	import bcte_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd.take_byte  = 1'b0;
		cmd.scan_start = 1'b0;
		cmd.issue      = 1'b0;
		busy           = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (operation == OP_BYTE) begin
						cmd.take_byte = 1'b1;
					end else if (layer_active) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.at_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/bcte_dp.sv -----
// datapath: report parser, colour table and two-stage brightness scaling pipeline
`default_nettype none

module bcte_dp #(
	parameter int NUM_BUTTONS = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bcte_pkg::cmd_t   cmd,
	input  wire logic [7:0]       report_byte,
	input  wire logic             last_in_report,
	input  wire logic [7:0]       brightness,
	output bcte_pkg::status_t     status,
	output logic                  result_strobe,
	output logic [4:0]            led_index,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic                  last_of_scan
);
	import bcte_pkg::*;

	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	// parser state
	phase_t             phase_q;
	logic               halted_q;
	logic [IDX_W-1:0]   target_q;
	logic [7:0]         held_red_q;
	logic [7:0]         held_green_q;

	// colour table with per-entry valid bits
	logic [23:0]            table_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] valid_q;

	// scan
	logic [IDX_W-1:0] cnt_q;
	logic [7:0]       bright_q;
	logic [23:0]      rd_colour;

	logic        v_s1;
	logic [15:0] red_prod_s1;
	logic [15:0] green_prod_s1;
	logic [15:0] blue_prod_s1;
	logic [4:0]  led_s1;
	logic        last_s1;

	logic [6:0]  btn;
	logic        btn_bad;

	assign btn     = report_byte[6:0];
	assign btn_bad = (btn == 7'd0) || (btn > 7'(NUM_BUTTONS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BUTTON;
			halted_q <= 1'b0;
			valid_q  <= '0;
		end else if (cmd.take_byte) begin
			if (!halted_q) begin
				case (phase_q)
					PH_BUTTON: begin
						if (report_byte == CLEAR_CODE) begin
							valid_q <= '0;
						end
					end
					PH_BLUE: begin
						valid_q[target_q] <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (last_in_report) begin
				phase_q  <= PH_BUTTON;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				case (phase_q)
					PH_BUTTON: begin
						if ((report_byte == CLEAR_CODE) || btn_bad) begin
							halted_q <= 1'b1;
						end else begin
							phase_q <= PH_RED;
						end
					end
					PH_RED: begin
						phase_q <= PH_GREEN;
					end
					PH_GREEN: begin
						phase_q <= PH_BLUE;
					end
					default: begin
						phase_q <= PH_BUTTON;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && !halted_q) begin
			case (phase_q)
				PH_BUTTON: begin
					target_q <= IDX_W'(btn - 7'd1);
				end
				PH_RED: begin
					held_red_q <= report_byte;
				end
				PH_GREEN: begin
					held_green_q <= report_byte;
				end
				PH_BLUE: begin
					table_q[target_q] <= {held_red_q, held_green_q, report_byte};
				end
				default: begin
				end
			endcase
		end
	end

	// scan counter and brightness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scan_start) begin
			cnt_q <= '0;
		end else if (cmd.issue && !status.at_last) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			bright_q <= brightness;
		end
	end

	assign status.at_last   = (cnt_q == IDX_W'(NUM_BUTTONS - 1));
	assign status.pipe_busy = v_s1;

	assign rd_colour = valid_q[cnt_q] ? table_q[cnt_q] : 24'd0;

	// stage 1: table read and multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			red_prod_s1   <= 16'(rd_colour[23:16]) * 16'(bright_q);
			green_prod_s1 <= 16'(rd_colour[15:8]) * 16'(bright_q);
			blue_prod_s1  <= 16'(rd_colour[7:0]) * 16'(bright_q);
			led_s1        <= LED_MAP[5'(cnt_q)];
			last_s1       <= status.at_last;
		end
	end

	// stage 2: divide by 255 into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			led_index    <= led_s1;
			red_out      <= div255(red_prod_s1);
			green_out    <= div255(green_prod_s1);
			blue_out     <= div255(blue_prod_s1);
			last_of_scan <= last_s1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bcte_chk.sv -----
// port-level checker for the button colour table engine and its bind
`default_nettype none

module bcte_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       operation,
	input wire logic       layer_active,
	input wire logic       result_strobe,
	input wire logic       last_of_scan
);
	import bcte_pkg::*;

	// a refresh with the layer on starts a scan
	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_REFRESH) && layer_active |=> busy)
		else $error("refresh item did not raise busy");

	// a report byte never stalls the next item
	a_byte_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_BYTE) |=> !busy)
		else $error("report byte item raised busy");

	// results of one scan come back to back
	a_scan_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_scan |=> result_strobe)
		else $error("gap inside a scan burst");

	// a scan ends with a gap before any further result
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_of_scan |=> !result_strobe)
		else $error("result right after last of scan");

	// results only appear while a scan holds busy or just after
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_strobe) |-> $past(busy))
		else $error("result without a scan in progress");

endmodule

bind button_colour_table_engine_core bcte_chk u_bcte_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.operation     (operation),
	.layer_active  (layer_active),
	.result_strobe (result_strobe),
	.last_of_scan  (last_of_scan)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for button_colour_table_engine_core: report parsing and scaled led refresh scans
`timescale 1ns / 100ps

module tb_top;
	import bcte_pkg::*;

	localparam int NUM_BTN   = 20;
	localparam int CYCLE_CAP = 400000;
	localparam int PRINT_CAP = 100;

	localparam logic [4:0] LED_POS [NUM_BTN] = '{
		5'd4, 5'd0, 5'd20, 5'd18,
		5'd7, 5'd1, 5'd21, 5'd16,
		5'd6, 5'd3, 5'd23, 5'd19,
		5'd9, 5'd11, 5'd15, 5'd13,
		5'd8, 5'd10, 5'd14, 5'd12
	};

	typedef struct packed {
		logic [4:0] led;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} led_colour_t;

	typedef logic [7:0] octet_q_t [$];

	class colour_scan_board;
		logic [23:0]  colours [NUM_BTN];
		phase_t       phase;
		logic [4:0]   target;
		logic [7:0]   held_red;
		logic [7:0]   held_green;
		logic         halted;
		led_colour_t  pending_leds [$];
		int           errors;

		function new();
			foreach (colours[i]) colours[i] = '0;
			phase      = PH_BUTTON;
			target     = '0;
			held_red   = '0;
			held_green = '0;
			halted     = 1'b0;
			errors     = 0;
		endfunction

		function automatic logic [7:0] scaled(logic [7:0] c, logic [7:0] b);
			int p;
			p = int'(c) * int'(b);
			return 8'(p / 255);
		endfunction

		function void note_item(logic op, logic [7:0] data, logic last,
					logic [7:0] bright, logic layer);
			logic [6:0]  btn;
			led_colour_t e;
			if (op == OP_BYTE) begin
				if (!halted) begin
					case (phase)
					PH_BUTTON: begin
						btn = data[6:0];
						if (data == CLEAR_CODE) begin
							foreach (colours[i]) colours[i] = '0;
							halted = 1'b1;
						end else if (btn == 7'd0 || int'(btn) > NUM_BTN) begin
							halted = 1'b1;
						end else begin
							target = 5'(btn - 7'd1);
							phase  = PH_RED;
						end
					end
					PH_RED: begin
						held_red = data;
						phase    = PH_GREEN;
					end
					PH_GREEN: begin
						held_green = data;
						phase      = PH_BLUE;
					end
					default: begin
						colours[target] = {held_red, held_green, data};
						phase           = PH_BUTTON;
					end
					endcase
				end
				if (last) begin
					phase  = PH_BUTTON;
					halted = 1'b0;
				end
			end else if (layer) begin
				for (int i = 0; i < NUM_BTN; i++) begin
					e.led   = LED_POS[i];
					e.red   = scaled(colours[i][23:16], bright);
					e.green = scaled(colours[i][15:8], bright);
					e.blue  = scaled(colours[i][7:0], bright);
					e.last  = (i == NUM_BTN - 1);
					pending_leds.push_back(e);
				end
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_scan_result(led_colour_t got);
			led_colour_t e;
			if (pending_leds.size() == 0) begin
				report_mismatch($sformatf("unexpected result led %0d rgb %02h%02h%02h last %0b",
					got.led, got.red, got.green, got.blue, got.last));
			end else begin
				e = pending_leds.pop_front();
				if (got.led !== e.led || got.red !== e.red || got.green !== e.green ||
				    got.blue !== e.blue || got.last !== e.last)
					report_mismatch($sformatf(
						"got led %0d rgb %02h%02h%02h last %0b, want led %0d rgb %02h%02h%02h last %0b",
						got.led, got.red, got.green, got.blue, got.last,
						e.led, e.red, e.green, e.blue, e.last));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n         = 1'b0;
	logic       start          = 1'b0;
	logic       busy;
	logic       operation      = OP_BYTE;
	logic [7:0] report_byte    = 8'd0;
	logic       last_in_report = 1'b0;
	logic [7:0] brightness     = 8'd0;
	logic       layer_active   = 1'b0;
	logic       result_strobe;
	logic [4:0] led_index;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       last_of_scan;

	colour_scan_board sb;
	int idle_pct   = 0;
	int items_sent = 0;
	int cycles     = 0;

	button_colour_table_engine_core #(.NUM_BUTTONS(NUM_BTN)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.report_byte(report_byte),
		.last_in_report(last_in_report),
		.brightness(brightness),
		.layer_active(layer_active),
		.result_strobe(result_strobe),
		.led_index(led_index),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.last_of_scan(last_of_scan)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("button_colour_table_engine_core verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.check_scan_result({led_index, red_out, green_out, blue_out, last_of_scan});
	end

	task automatic issue_item(input logic op, input logic [7:0] data, input logic last,
				  input logic [7:0] bright, input logic layer);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		operation      <= op;
		report_byte    <= data;
		last_in_report <= last;
		brightness     <= bright;
		layer_active   <= layer;
		do @(posedge clk); while (busy);
		sb.note_item(op, data, last, bright, layer);
		items_sent++;
	endtask

	task automatic issue_refresh(input logic [7:0] bright, input logic layer);
		issue_item(OP_REFRESH, 8'($urandom), 1'($urandom), bright, layer);
	endtask

	task automatic issue_random_refresh();
		int pick;
		logic [7:0] bright;
		pick = $urandom_range(9);
		bright = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
		issue_refresh(bright, $urandom_range(3) != 0);
	endtask

	// final byte carries the end-of-report mark
	task automatic issue_report(input octet_q_t q, input int refresh_pct);
		for (int i = 0; i < q.size(); i++) begin
			if ($urandom_range(99) < refresh_pct)
				issue_random_refresh();
			issue_item(OP_BYTE, q[i], i == q.size() - 1, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic issue_random_report();
		octet_q_t   q;
		int         kind;
		logic [7:0] b;
		repeat ($urandom_range(1, 4)) begin
			b    = 8'($urandom_range(1, NUM_BTN));
			b[7] = 1'($urandom);
			q.push_back(b);
			repeat (3) q.push_back(8'($urandom));
		end
		kind = $urandom_range(99);
		if (kind < 10) begin
			q.push_back(CLEAR_CODE);
			repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
		end else if (kind < 20) begin
			b    = $urandom_range(1) ? 8'd0 : 8'($urandom_range(NUM_BTN + 1, 127));
			b[7] = 1'($urandom);
			q.push_back(b);
			repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
		end else if (kind < 30) begin
			b    = 8'($urandom_range(1, NUM_BTN));
			b[7] = 1'($urandom);
			q.push_back(b);
			repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
		end
		issue_report(q, 4);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending_leds.size() != 0);
	endtask

	initial begin
		int pick;
		int goal;
		int phase_pct [4];
		sb = new();
		phase_pct = '{0, 61, 31, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		issue_refresh(8'd255, 1'b1);
		issue_report('{8'h01, 8'hFF, 8'h00, 8'h80, 8'h94, 8'h55, 8'hAA, 8'h01}, 0);
		issue_refresh(8'd255, 1'b1);
		issue_refresh(8'd0, 1'b1);
		issue_refresh(8'd128, 1'b1);
		issue_refresh(8'd200, 1'b0);
		// invalid buttons halt the report until its final byte
		issue_report('{8'h15, 8'h01, 8'h02}, 0);
		issue_report('{8'h80, 8'h33}, 0);
		// cut-off record is dropped
		issue_report('{8'h03, 8'h10}, 0);
		issue_report('{CLEAR_CODE, 8'h05}, 0);
		issue_refresh(8'd255, 1'b1);
		drain_results();

		goal = items_sent;
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			goal += 57;
			while (items_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 70)
					issue_random_report();
				else if (pick < 85)
					issue_random_refresh();
				else
					repeat ($urandom_range(1, 4))
						issue_item(OP_BYTE, 8'($urandom), $urandom_range(3) == 0,
							8'($urandom), 1'($urandom));
			end
			drain_results();
		end

		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("button_colour_table_engine_core verification clean");
		else
			$display("button_colour_table_engine_core verification failed");
		$finish;
	end

endmodule
